// File: hw/rtl/rhb_pkg.sv
// Shared types, codes and sizes of the range histogram builder.
`timescale 1ns / 1ps
`default_nettype none
package rhb_pkg;

  localparam int MAX_BINS    = 512;
  localparam int MAX_SAMPLES = 4096;

  localparam int VAL_W   = 32;
  localparam int BIN_W   = 10;                       // bin count, 0..MAX_BINS
  localparam int BADDR_W = $clog2(MAX_BINS);
  localparam int SADDR_W = $clog2(MAX_SAMPLES);
  localparam int TOT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int CNT_W   = 13;
  localparam int SQ_W    = 2 * BIN_W;
  localparam int PROD_W  = VAL_W + BIN_W;
  localparam int SMP_W   = VAL_W + 1;
  localparam int STEP_W  = $clog2(PROD_W + 1);

  localparam logic [CNT_W-1:0] COUNT_MAX = 13'd8191;
  localparam logic [BIN_W-1:0] MIN_AUTO_BINS = 10'd4;

  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FLAT  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_NOBIN = 2'd3;

  localparam logic REG_AUTO  = 1'b0;
  localparam logic REG_FIXED = 1'b1;

  typedef struct packed {
    logic [1:0]        command;
    logic [VAL_W-1:0]  sample_value;
    logic              sample_valid;
    logic [8:0]        bin_select;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [9:0]        bin_count_used;
    logic [VAL_W-1:0]  bin_left_edge;
    logic [CNT_W-1:0]  bin_total;
  } out_word_t;

  typedef enum logic [1:0] {
    RES_BUILD,
    RES_FLAT,
    RES_READ
  } res_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic idx_clr;
    logic smp_rd;
    logic scan_chk;
    logic sq_step;
    logic bins_set;
    logic clr_step;
    logic h_off;
    logic h_mul;
    logic r_mul;
    logic div_start;
    logic div_hist;
    logic bin_rd_hist;
    logic bin_rd_sel;
    logic bin_inc;
    logic commit;
    logic out_load;
    res_e res;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;
    logic read_ok;
    logic scan_end;
    logic flat;
    logic auto_mode;
    logic sq_more;
    logic clr_last;
    logic cur_valid;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

// File: hw/rtl/rhb_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module rhb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/rhb_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module rhb_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [rhb_pkg::PROD_W-1:0] dividend_i,
  input  wire logic [rhb_pkg::VAL_W-1:0]  divisor_i,
  output logic                            done_o,
  output logic      [rhb_pkg::PROD_W-1:0] quotient_o
);

  logic                          busy_q, busy_d, done_q, done_d;
  logic [rhb_pkg::STEP_W-1:0]    cnt_q, cnt_d;
  logic [rhb_pkg::VAL_W-1:0]     dvs_q, dvs_d;
  logic [rhb_pkg::VAL_W:0]       rem_q, rem_d;
  logic [rhb_pkg::PROD_W-1:0]    quo_q, quo_d;
  logic [rhb_pkg::VAL_W+1:0]     shifted;
  logic [rhb_pkg::VAL_W+1:0]     diff;

  assign shifted = {rem_q, quo_q[rhb_pkg::PROD_W-1]};
  assign diff    = shifted - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = rhb_pkg::STEP_W'(rhb_pkg::PROD_W);
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      if (!diff[rhb_pkg::VAL_W+1]) begin
        rem_d = diff[rhb_pkg::VAL_W:0];
      end else begin
        rem_d = shifted[rhb_pkg::VAL_W:0];
      end
      quo_d = {quo_q[rhb_pkg::PROD_W-2:0], ~diff[rhb_pkg::VAL_W+1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == rhb_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
`default_nettype wire

// File: hw/rtl/rhb_dp.sv
// Datapath: sample and bin stores, min/max scan, bin math, result register.
`timescale 1ns / 1ps
`default_nettype none
module rhb_dp (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire rhb_pkg::in_word_t         in_word_i,
  input  wire logic                      auto_mode_i,
  input  wire logic [rhb_pkg::BIN_W-1:0] fixed_bins_i,
  input  wire rhb_pkg::cmd_t             cmd_i,
  output rhb_pkg::stat_t                 stat_o,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output rhb_pkg::out_word_t             out_word_o
);

  logic [rhb_pkg::TOT_W-1:0]   total_q, total_d, idx_q, idx_d;
  logic [rhb_pkg::BADDR_W-1:0] sel_q, sel_d, cidx_q, cidx_d, binx_q, binx_d;
  logic signed [rhb_pkg::VAL_W-1:0] slo_q, slo_d, shi_q, shi_d, lo_q, lo_d, hi_q, hi_d;
  logic                        any_q, any_d, ready_q, ready_d, out_valid_q, out_valid_d;
  logic [rhb_pkg::BIN_W-1:0]   n_q, n_d, bnew_q, bnew_d, bins_q, bins_d;
  logic [rhb_pkg::SQ_W-1:0]    sq_q, sq_d;
  logic [rhb_pkg::VAL_W-1:0]   off_q, off_d;
  logic [rhb_pkg::PROD_W-1:0]  prod_q, prod_d;
  rhb_pkg::out_word_t          out_q, out_d;

  logic [rhb_pkg::SMP_W-1:0]   smp_rdata;
  logic [rhb_pkg::CNT_W-1:0]   bin_rdata, bin_wdata;
  logic [rhb_pkg::BADDR_W-1:0] bin_waddr, bin_raddr, hist_idx;
  logic                        bin_we, smp_we, full, read_ok, out_free, imm, out_ld;
  logic signed [rhb_pkg::VAL_W-1:0] cur_v;
  logic [rhb_pkg::VAL_W:0]     range_s_w, range_c_w, off_w;
  logic [rhb_pkg::VAL_W-1:0]   range_s, range_c, divisor;
  logic [rhb_pkg::BIN_W-1:0]   bmax;
  logic                        div_done;
  logic [rhb_pkg::PROD_W-1:0]  quo;

  assign cur_v     = $signed(smp_rdata[rhb_pkg::VAL_W-1:0]);
  assign range_s_w = {shi_q[rhb_pkg::VAL_W-1], shi_q} - {slo_q[rhb_pkg::VAL_W-1], slo_q};
  assign range_c_w = {hi_q[rhb_pkg::VAL_W-1], hi_q} - {lo_q[rhb_pkg::VAL_W-1], lo_q};
  assign off_w     = {cur_v[rhb_pkg::VAL_W-1], cur_v} - {slo_q[rhb_pkg::VAL_W-1], slo_q};
  assign range_s   = range_s_w[rhb_pkg::VAL_W-1:0];
  assign range_c   = range_c_w[rhb_pkg::VAL_W-1:0];
  assign divisor   = cmd_i.div_hist ? range_s : rhb_pkg::VAL_W'(bins_q);

  assign full     = (total_q == rhb_pkg::TOT_W'(rhb_pkg::MAX_SAMPLES));
  assign read_ok  = ready_q && ({1'b0, in_word_i.bin_select} < bins_q);
  assign out_free = !out_valid_q || !out_stall_i;
  // push, clear and a read that misses answer in the accept cycle
  assign imm = cmd_i.accept && !(in_word_i.command == rhb_pkg::CMD_BUILD) &&
               !(in_word_i.command == rhb_pkg::CMD_READ && read_ok);
  assign out_ld = imm || cmd_i.out_load;

  assign bmax     = bnew_q - 1'b1;
  assign hist_idx = (quo > rhb_pkg::PROD_W'(bmax)) ? bmax[rhb_pkg::BADDR_W-1:0]
                                                   : quo[rhb_pkg::BADDR_W-1:0];

  assign smp_we    = cmd_i.accept && (in_word_i.command == rhb_pkg::CMD_PUSH) && !full;
  assign bin_we    = cmd_i.clr_step || cmd_i.bin_inc;
  assign bin_waddr = cmd_i.clr_step ? cidx_q : binx_q;
  assign bin_wdata = cmd_i.clr_step ? '0 :
                     (bin_rdata < rhb_pkg::COUNT_MAX) ? bin_rdata + 1'b1 : bin_rdata;
  assign bin_raddr = cmd_i.bin_rd_hist ? hist_idx : sel_q;

  always_comb begin
    total_d = total_q; idx_d = idx_q; sel_d = sel_q; cidx_d = cidx_q; binx_d = binx_q;
    slo_d = slo_q; shi_d = shi_q; lo_d = lo_q; hi_d = hi_q;
    any_d = any_q; ready_d = ready_q;
    n_d = n_q; sq_d = sq_q; bnew_d = bnew_q; bins_d = bins_q;
    off_d = off_q; prod_d = prod_q; out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    if (cmd_i.accept) begin
      sel_d = in_word_i.bin_select;
      n_d   = '0;
      sq_d  = '0;
      if (in_word_i.command == rhb_pkg::CMD_CLEAR) begin
        total_d = '0;
      end else if (smp_we) begin
        total_d = total_q + 1'b1;
      end
    end
    if (cmd_i.idx_clr) begin
      idx_d = '0;
      any_d = 1'b0;
    end
    if (cmd_i.scan_chk) begin
      idx_d = idx_q + 1'b1;
      if (smp_rdata[rhb_pkg::VAL_W]) begin
        any_d = 1'b1;
        if (!any_q || cur_v < slo_q) slo_d = cur_v;
        if (!any_q || cur_v > shi_q) shi_d = cur_v;
      end
    end
    if (cmd_i.sq_step) begin
      n_d  = n_q + 1'b1;
      sq_d = sq_q + rhb_pkg::SQ_W'({n_q, 1'b1});
    end
    if (cmd_i.bins_set) begin
      cidx_d = '0;
      if (auto_mode_i) begin
        bnew_d = (n_q < rhb_pkg::MIN_AUTO_BINS) ? rhb_pkg::MIN_AUTO_BINS : n_q;
      end else if (fixed_bins_i == '0) begin
        bnew_d = rhb_pkg::BIN_W'(1);
      end else if (fixed_bins_i > rhb_pkg::BIN_W'(rhb_pkg::MAX_BINS)) begin
        bnew_d = rhb_pkg::BIN_W'(rhb_pkg::MAX_BINS);
      end else begin
        bnew_d = fixed_bins_i;
      end
    end
    if (cmd_i.clr_step) begin
      cidx_d = cidx_q + 1'b1;
    end
    if (cmd_i.h_off) begin
      idx_d = idx_q + 1'b1;
      off_d = off_w[rhb_pkg::VAL_W-1:0];
    end
    if (cmd_i.h_mul) begin
      prod_d = off_q * bnew_q;
    end
    if (cmd_i.r_mul) begin
      prod_d = rhb_pkg::PROD_W'(sel_q * range_c);
    end
    if (cmd_i.bin_rd_hist) begin
      binx_d = hist_idx;
    end
    if (cmd_i.commit) begin
      lo_d    = slo_q;
      hi_d    = shi_q;
      bins_d  = bnew_q;
      ready_d = 1'b1;
    end

    if (out_ld) begin
      out_valid_d              = 1'b1;
      out_d.status             = rhb_pkg::ST_OK;
      out_d.bin_count_used     = (cmd_i.commit) ? bnew_q : bins_q;
      out_d.bin_left_edge      = '0;
      out_d.bin_total          = '0;
      if (imm) begin
        if (in_word_i.command == rhb_pkg::CMD_PUSH && full) begin
          out_d.status = rhb_pkg::ST_FULL;
        end else if (in_word_i.command == rhb_pkg::CMD_READ) begin
          out_d.status = rhb_pkg::ST_NOBIN;
        end
      end else begin
        case (cmd_i.res)
          rhb_pkg::RES_FLAT: out_d.status = rhb_pkg::ST_FLAT;
          rhb_pkg::RES_READ: begin
            out_d.bin_left_edge = lo_q + quo[rhb_pkg::VAL_W-1:0];
            out_d.bin_total     = bin_rdata;
          end
          default: out_d.status = rhb_pkg::ST_OK;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= '0;
      idx_q       <= '0;
      cidx_q      <= '0;
      any_q       <= 1'b0;
      ready_q     <= 1'b0;
      n_q         <= '0;
      sq_q        <= '0;
      bnew_q      <= '0;
      bins_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      total_q     <= total_d;
      idx_q       <= idx_d;
      cidx_q      <= cidx_d;
      any_q       <= any_d;
      ready_q     <= ready_d;
      n_q         <= n_d;
      sq_q        <= sq_d;
      bnew_q      <= bnew_d;
      bins_q      <= bins_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q  <= sel_d;
    binx_q <= binx_d;
    slo_q  <= slo_d;
    shi_q  <= shi_d;
    off_q  <= off_d;
    prod_q <= prod_d;
    out_q  <= out_d;
  end

  rhb_ram #(
    .WIDTH(rhb_pkg::SMP_W),
    .DEPTH(rhb_pkg::MAX_SAMPLES)
  ) u_smp_ram (
    .clk_i   (clk_i),
    .we_i    (smp_we),
    .waddr_i (total_q[rhb_pkg::SADDR_W-1:0]),
    .wdata_i ({in_word_i.sample_valid, in_word_i.sample_value}),
    .re_i    (cmd_i.smp_rd),
    .raddr_i (idx_q[rhb_pkg::SADDR_W-1:0]),
    .rdata_o (smp_rdata)
  );

  rhb_ram #(
    .WIDTH(rhb_pkg::CNT_W),
    .DEPTH(rhb_pkg::MAX_BINS)
  ) u_bin_ram (
    .clk_i   (clk_i),
    .we_i    (bin_we),
    .waddr_i (bin_waddr),
    .wdata_i (bin_wdata),
    .re_i    (cmd_i.bin_rd_hist || cmd_i.bin_rd_sel),
    .raddr_i (bin_raddr),
    .rdata_o (bin_rdata)
  );

  rhb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (prod_q),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    stat_o.out_free  = out_free;
    stat_o.read_ok   = read_ok;
    stat_o.scan_end  = (idx_q == total_q);
    stat_o.flat      = !any_q || (slo_q == shi_q);
    stat_o.auto_mode = auto_mode_i;
    stat_o.sq_more   = ({7'b0, total_q} > sq_q) && (n_q < rhb_pkg::BIN_W'(rhb_pkg::MAX_BINS));
    stat_o.clr_last  = (cidx_q == rhb_pkg::BADDR_W'(rhb_pkg::MAX_BINS - 1));
    stat_o.cur_valid = smp_rdata[rhb_pkg::VAL_W];
    stat_o.div_done  = div_done;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef SYNTH
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ld |-> (!out_valid_q || !out_stall_i))
    else $error("result word overwritten while stalled");
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= rhb_pkg::TOT_W'(rhb_pkg::MAX_SAMPLES))
    else $error("sample count beyond store depth");
  a_bins_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (bins_q != '0 && bins_q <= rhb_pkg::BIN_W'(rhb_pkg::MAX_BINS)))
    else $error("committed bin count out of range");
  a_hist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (shi_q > slo_q))
    else $error("histogram committed on flat range");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/rhb_ctrl.sv
// Controller state machine sequencing push, build and read.
`timescale 1ns / 1ps
`default_nettype none
module rhb_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [1:0]     command_i,
  output logic                in_stall_o,
  input  wire rhb_pkg::stat_t stat_i,
  output rhb_pkg::cmd_t       cmd_o
);

  typedef enum logic [13:0] {
    S_IDLE     = 14'h0001,
    S_SCAN_RD  = 14'h0002,
    S_SCAN_CHK = 14'h0004,
    S_EVAL     = 14'h0008,
    S_SQRT     = 14'h0010,
    S_BINSET   = 14'h0020,
    S_CLR      = 14'h0040,
    S_H_RD     = 14'h0080,
    S_H_OFF    = 14'h0100,
    S_H_MUL    = 14'h0200,
    S_DIV      = 14'h0400,
    S_BRD      = 14'h0800,
    S_H_BWR    = 14'h1000,
    S_FIN      = 14'h2000
  } state_e;

  state_e         state_q, state_d;
  rhb_pkg::res_e  res_q, res_d;
  logic           hist_q, hist_d;   // divider serves histogram (1) or read (0)
  // divider start, raised in the cycle after the multiply, with the product in place
  logic           div_arm_q;

  assign in_stall_o = !((state_q == S_IDLE) && stat_i.out_free);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    hist_d  = hist_q;
    cmd_o   = '0;
    cmd_o.div_hist  = hist_q;
    cmd_o.res       = res_q;
    cmd_o.div_start = div_arm_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && stat_i.out_free) begin
          cmd_o.accept = 1'b1;
          if (command_i == rhb_pkg::CMD_BUILD) begin
            cmd_o.idx_clr = 1'b1;
            state_d = S_SCAN_RD;
          end else if (command_i == rhb_pkg::CMD_READ && stat_i.read_ok) begin
            hist_d  = 1'b0;
            res_d   = rhb_pkg::RES_READ;
            state_d = S_H_MUL;
          end
        end
      end
      S_SCAN_RD: begin
        if (stat_i.scan_end) begin
          state_d = S_EVAL;
        end else begin
          cmd_o.smp_rd = 1'b1;
          state_d = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        cmd_o.scan_chk = 1'b1;
        state_d = S_SCAN_RD;
      end
      S_EVAL: begin
        if (stat_i.flat) begin
          res_d   = rhb_pkg::RES_FLAT;
          state_d = S_FIN;
        end else begin
          state_d = stat_i.auto_mode ? S_SQRT : S_BINSET;
        end
      end
      S_SQRT: begin
        // walk n up until n*n reaches the sample count
        if (stat_i.sq_more) begin
          cmd_o.sq_step = 1'b1;
        end else begin
          state_d = S_BINSET;
        end
      end
      S_BINSET: begin
        cmd_o.bins_set = 1'b1;
        state_d = S_CLR;
      end
      S_CLR: begin
        cmd_o.clr_step = 1'b1;
        if (stat_i.clr_last) begin
          cmd_o.idx_clr = 1'b1;
          hist_d  = 1'b1;
          state_d = S_H_RD;
        end
      end
      S_H_RD: begin
        if (stat_i.scan_end) begin
          cmd_o.commit   = 1'b1;
          cmd_o.out_load = stat_i.out_free;
          cmd_o.res      = rhb_pkg::RES_BUILD;
          res_d   = rhb_pkg::RES_BUILD;
          state_d = stat_i.out_free ? S_IDLE : S_FIN;
        end else begin
          cmd_o.smp_rd = 1'b1;
          state_d = S_H_OFF;
        end
      end
      S_H_OFF: begin
        cmd_o.h_off = 1'b1;
        state_d = stat_i.cur_valid ? S_H_MUL : S_H_RD;
      end
      S_H_MUL: begin
        cmd_o.h_mul = hist_q;
        cmd_o.r_mul = !hist_q;
        state_d = S_DIV;
      end
      S_DIV: begin
        // first cycle here loads the divider from the product register
        if (stat_i.div_done) begin
          state_d = S_BRD;
        end
      end
      S_BRD: begin
        cmd_o.bin_rd_hist = hist_q;
        cmd_o.bin_rd_sel  = !hist_q;
        state_d = hist_q ? S_H_BWR : S_FIN;
      end
      S_H_BWR: begin
        cmd_o.bin_inc = 1'b1;
        state_d = S_H_RD;
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      res_q     <= rhb_pkg::RES_BUILD;
      hist_q    <= 1'b0;
      div_arm_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_q     <= res_d;
      hist_q    <= hist_d;
      div_arm_q <= (state_q == S_H_MUL);
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/range_histogram_builder_unit.sv
// Top level of the range histogram builder: configuration port and block wiring.
`timescale 1ns / 1ps
`default_nettype none
// Signed Q15.16 samples are pushed into a 4096-entry store, one word per cycle
// while the output register is free; push, clear and a read of an unavailable
// bin load the result register at the edge that takes them. A build scans the
// store twice: min/max reads and then checks each stored sample, automatic bin
// choice steps n up (n stops at 64 for a full store), the 512-entry bin memory
// is cleared entry by entry, then the 42-step bit-serial divider computes the
// bin of each valid sample from its scaled offset and that bin is counted up;
// invalid samples are skipped. A bin read loads its result via the same divider.
// Results leave through an output register; a new word is taken only while it
// is empty or being emptied in the same cycle. No clearing pass follows reset.
module range_histogram_builder_unit (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rhb_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output rhb_pkg::out_word_t      out_word_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [2:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  logic                      auto_q, auto_d;
  logic [rhb_pkg::BIN_W-1:0] fixed_q, fixed_d;
  logic                      wr_en;
  rhb_pkg::cmd_t             cmd;
  rhb_pkg::stat_t            stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    auto_d  = auto_q;
    fixed_d = fixed_q;
    if (wr_en) begin
      case (paddr[2])
        rhb_pkg::REG_AUTO:  auto_d  = pwdata[0];
        rhb_pkg::REG_FIXED: fixed_d = pwdata[rhb_pkg::BIN_W-1:0];
        default: auto_d = auto_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      rhb_pkg::REG_AUTO:  prdata = {31'b0, auto_q};
      rhb_pkg::REG_FIXED: prdata = {22'b0, fixed_q};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q  <= 1'b1;
      fixed_q <= 10'd64;
    end else begin
      auto_q  <= auto_d;
      fixed_q <= fixed_d;
    end
  end

  rhb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .command_i  (in_word_i.command),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rhb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_word_i    (in_word_i),
    .auto_mode_i  (auto_q),
    .fixed_bins_i (fixed_q),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

endmodule
`default_nettype wire
